/* hdl/vrq_pkg.sv */
// Package for the voice envelope ramp block: item layouts, mode codes and
// the envelope target and rate decode functions. Depends on nothing.

package vrq_pkg;

  localparam int VOL_W   = 26;
  localparam int VOICE_W = 5;
  localparam int BYTE_W  = 8;
  localparam int ENV_W   = 16;
  localparam int MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENV      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VOLUME   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IRQ_READ = 3'd4;

  localparam logic [BYTE_W-1:0] RATE_JUMP = 8'hff;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VOICE_W-1:0] voice;
    logic [BYTE_W-1:0]  env_rate;
    logic [BYTE_W-1:0]  env_target;
    logic               enable;
    logic [VOL_W-1:0]   volume_value;
  } cmd_t;

  typedef struct packed {
    logic [VOL_W-1:0]   volume_out;
    logic [VOICE_W-1:0] irq_voice;
    logic               irq_line;
    logic               completed;
  } res_t;

  function automatic logic [VOL_W-1:0] target_level(input logic [BYTE_W-1:0] code);
    logic [4:0]  mant;
    logic [3:0]  hi;
    logic [12:0] units;
    mant = {1'b1, code[3:0] & 4'h0f};
    hi   = code[7:4];
    if (hi >= 4'd7) begin
      units = 13'(mant) << (hi - 4'd7);
    end else begin
      units = 13'(mant) >> (4'd7 - hi);
    end
    if (code < 8'h30) begin
      return '0;
    end
    return {units, 13'b0};
  endfunction

  function automatic logic [VOL_W-1:0] rate_increment(input logic [BYTE_W-1:0] rate);
    logic [3:0] group;
    group = rate[6:3];
    if (rate == 8'h00) begin
      return '0;
    end
    if (rate < 8'h80) begin
      return VOL_W'({1'b1, rate[2:0]}) << (5'd3 + 5'(rate[6:3]));
    end
    if (group != 4'd15) begin
      return VOL_W'(5'd16 - 5'(rate[2:0])) << (4'd14 - group);
    end
    return VOL_W'(4'd8 - 4'(rate[2:0]));
  endfunction

endpackage

/* hdl/vrq_stream_if.sv */
// Valid/ready stream interface that carries one beat of a payload type.
// The payload types come from vrq_pkg at the point of instantiation.

interface vrq_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/voice_envelope_ramp_with_irq_queue.sv */
// Per-voice envelope ramp generator with a completion interrupt queue.
// Depends on vrq_pkg and vrq_stream_if.
// The result beat is registered: it is valid in the cycle after its command beat is taken.
// Throughput: one command per cycle while no untaken result beat holds off cmd.ready,
// set by the read-modify-write of the addressed voice's registers and the queue pointers.
// Reset (synchronous, rst high) clears all voice state, the queue pointers and count,
// the current interrupt and the result valid flag.

module voice_envelope_ramp_with_irq_queue #(
  parameter int VOICES = 32
) (
  input  logic         clk,
  input  logic         rst,
  vrq_stream_if.sink   cmd,
  vrq_stream_if.source res
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(VOICES);

  logic [vrq_pkg::VOL_W-1:0]   volume [VOICES];
  logic [vrq_pkg::ENV_W-1:0]   env_word [VOICES];
  logic [VOICES-1:0]           enabled;
  logic [VOICES-1:0]           ramp;
  logic [vrq_pkg::VOICE_W-1:0] fifo [VOICES];
  logic [IDX_W-1:0]            rd_ptr;
  logic [IDX_W-1:0]            wr_ptr;
  logic [CNT_W-1:0]            count;
  logic [vrq_pkg::VOICE_W-1:0] irq_voice;
  logic                        irq_valid;
  logic                        res_valid;
  vrq_pkg::res_t               res_q;

  vrq_pkg::cmd_t               c;
  logic                        cmd_fire;
  logic                        ok;
  logic [IDX_W-1:0]            idx;
  logic [vrq_pkg::VOL_W-1:0]   cur_vol;
  logic [vrq_pkg::ENV_W-1:0]   cur_env;
  logic [vrq_pkg::ENV_W-1:0]   new_env;
  logic                        cur_en;
  logic                        cur_ramp;
  logic [vrq_pkg::VOL_W-1:0]   target;
  logic [vrq_pkg::VOL_W-1:0]   inc;
  logic [vrq_pkg::VOL_W-1:0]   vol_t;
  logic                        ramp_t;

  logic [vrq_pkg::VOL_W-1:0]   vol_next;
  logic [vrq_pkg::ENV_W-1:0]   env_next;
  logic                        en_next;
  logic                        ramp_next;
  logic                        done;
  logic                        pop;
  logic [vrq_pkg::VOICE_W-1:0] irqv;
  logic                        irq_valid_next;
  logic [vrq_pkg::VOICE_W-1:0] irq_voice_next;
  logic                        fifo_we;
  logic                        rd_adv;
  logic [CNT_W-1:0]            count_next;
  logic [IDX_W-1:0]            rd_ptr_next;
  logic [IDX_W-1:0]            wr_ptr_next;

  assign c         = cmd.data;
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign ok        = (6'(c.voice) < 6'(VOICES));
  assign idx       = c.voice[IDX_W-1:0];

  assign cur_vol  = volume[idx];
  assign cur_env  = env_word[idx];
  assign cur_en   = enabled[idx];
  assign cur_ramp = ramp[idx];
  assign new_env  = {c.env_target, c.env_rate};
  assign target   = vrq_pkg::target_level(cur_env[15:8]);
  assign inc      = vrq_pkg::rate_increment(cur_env[7:0]);
  assign vol_t    = (cur_env[7:0] == vrq_pkg::RATE_JUMP) ? target : cur_vol;
  assign ramp_t   = (cur_env[7:0] == vrq_pkg::RATE_JUMP) ? 1'b0 : cur_ramp;

  always_comb begin
    vol_next  = cur_vol;
    env_next  = cur_env;
    en_next   = cur_en;
    ramp_next = cur_ramp;
    done      = 1'b0;
    pop       = 1'b0;
    irqv      = '0;
    unique case (c.mode)
      vrq_pkg::MODE_TICK: begin
        if (ok && cur_en) begin
          if (vol_t < target) begin
            if (inc >= target - vol_t) begin
              vol_next  = target;
              ramp_next = 1'b0;
              done      = 1'b1;
            end else begin
              vol_next  = vol_t + inc;
              ramp_next = 1'b1;
            end
          end else if (vol_t > target) begin
            if (inc >= vol_t - target) begin
              vol_next  = target;
              ramp_next = 1'b0;
              done      = 1'b1;
            end else begin
              vol_next  = vol_t - inc;
              ramp_next = 1'b1;
            end
          end else begin
            vol_next  = vol_t;
            ramp_next = 1'b0;
            done      = ramp_t;
          end
        end
      end
      vrq_pkg::MODE_ENV: begin
        env_next = new_env;
        if (cur_en && (cur_env != new_env)) begin
          ramp_next = 1'b1;
        end
      end
      vrq_pkg::MODE_ENABLE: begin
        if (c.enable && !cur_en) begin
          ramp_next = 1'b1;
        end
        en_next = c.enable;
      end
      vrq_pkg::MODE_VOLUME: begin
        vol_next = c.volume_value;
      end
      vrq_pkg::MODE_IRQ_READ: begin
        irqv = irq_voice;
        pop  = irq_valid;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    irq_valid_next = irq_valid;
    irq_voice_next = irq_voice;
    fifo_we        = 1'b0;
    rd_adv         = 1'b0;
    if (done) begin
      if (!irq_valid) begin
        irq_valid_next = 1'b1;
        irq_voice_next = c.voice;
      end else if (count != FULL_CNT) begin
        fifo_we = 1'b1;
      end
    end
    if (pop) begin
      if (count != '0) begin
        irq_voice_next = fifo[rd_ptr];
        rd_adv         = 1'b1;
      end else begin
        irq_valid_next = 1'b0;
      end
    end
  end

  assign count_next  = count + CNT_W'(fifo_we) - CNT_W'(rd_adv);
  assign rd_ptr_next = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_next = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        volume[i]   <= '0;
        env_word[i] <= '0;
      end
      enabled   <= '0;
      ramp      <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      irq_voice <= '0;
      irq_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_fire) begin
        if (ok) begin
          volume[idx]   <= vol_next;
          env_word[idx] <= env_next;
          enabled[idx]  <= en_next;
          ramp[idx]     <= ramp_next;
        end
        irq_valid <= irq_valid_next;
        irq_voice <= irq_voice_next;
        count     <= count_next;
        if (fifo_we) begin
          wr_ptr <= wr_ptr_next;
        end
        if (rd_adv) begin
          rd_ptr <= rd_ptr_next;
        end
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      if (fifo_we) begin
        fifo[wr_ptr] <= c.voice;
      end
      res_q.volume_out <= ok ? vol_next : '0;
      res_q.irq_voice  <= irqv;
      res_q.irq_line   <= irq_valid_next;
      res_q.completed  <= done;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_q;

  a_queue_implies_current: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> irq_valid)
    else $error("Queued interrupts without a current interrupt.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("Interrupt queue count exceeds its depth.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> res_valid)
    else $error("Accepted command beat produced no result beat.");

endmodule

/* verif/vrq_checker.sv */
// Scoreboard for the voice envelope ramp block: predicts each result beat from the
// command beats it sees and compares it with the beats the block returns.
// Depends on vrq_pkg for the beat layouts and mode codes.

module vrq_checker
  import vrq_pkg::*;
#(
  parameter int VOICES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd_data,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res_data,
  output int   errors,
  output int   waiting,
  output int   beats,
  output int   completions,
  output int   drops
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VOL_W-1:0]   vol_mem [32];
  logic [ENV_W-1:0]   env_mem [32];
  logic               on_mem [32];
  logic               ramp_mem [32];
  logic [VOICE_W-1:0] irq_backlog [$];
  logic [VOICE_W-1:0] irq_head;
  logic               irq_held;
  res_t               expected_results [$];
  int                 err_n;
  int                 beat_n;
  int                 done_n;
  int                 drop_n;

  function automatic logic [31:0] level_of(input logic [BYTE_W-1:0] code);
    logic [31:0] units;
    int          expo;
    if (code < 8'h30) begin
      return 32'd0;
    end
    units = {27'd0, 1'b1, code[3:0]};
    expo  = int'(code[7:4]) - 7;
    if (expo >= 0) begin
      units = units << expo;
    end else begin
      units = units >> (-expo);
    end
    return units << 13;
  endfunction

  function automatic logic [31:0] step_of(input logic [BYTE_W-1:0] rate);
    int grp;
    grp = int'(rate[6:3]);
    if (rate == 8'h00) begin
      return 32'd0;
    end
    if (rate < 8'h80) begin
      return (32'd8 | 32'(rate[2:0])) << (3 + grp);
    end
    if (grp < 15) begin
      return (32'd16 - 32'(rate[2:0])) << (14 - grp);
    end
    return 32'd8 - 32'(rate[2:0]);
  endfunction

  function automatic void post_irq(input logic [VOICE_W-1:0] v);
    done_n++;
    if (!irq_held) begin
      irq_head = v;
      irq_held = 1'b1;
    end else if (irq_backlog.size() < VOICES) begin
      irq_backlog.push_back(v);
    end else begin
      drop_n++;
    end
  endfunction

  function automatic res_t apply_beat(input cmd_t c);
    res_t              r;
    logic [31:0]       lvl;
    logic [31:0]       inc;
    logic [31:0]       vol;
    logic [BYTE_W-1:0] rt;
    logic              was;
    logic              ok;
    int                v;
    r  = '0;
    v  = int'(c.voice);
    ok = v < VOICES;
    if (c.mode == MODE_TICK && ok && on_mem[v]) begin
      vol = 32'(vol_mem[v]);
      rt  = env_mem[v][7:0];
      lvl = level_of(env_mem[v][15:8]);
      inc = step_of(rt);
      if (rt == RATE_JUMP) begin
        vol = lvl;
        ramp_mem[v] = 1'b0;
      end
      was = ramp_mem[v];
      if (vol < lvl) begin
        if (inc >= lvl - vol) begin
          vol = lvl;
          ramp_mem[v] = 1'b0;
          post_irq(c.voice);
          r.completed = 1'b1;
        end else begin
          vol = vol + inc;
          ramp_mem[v] = 1'b1;
        end
      end else if (vol > lvl) begin
        if (inc >= vol - lvl) begin
          vol = lvl;
          ramp_mem[v] = 1'b0;
          post_irq(c.voice);
          r.completed = 1'b1;
        end else begin
          vol = vol - inc;
          ramp_mem[v] = 1'b1;
        end
      end else begin
        ramp_mem[v] = 1'b0;
        if (was) begin
          post_irq(c.voice);
          r.completed = 1'b1;
        end
      end
      vol_mem[v] = vol[VOL_W-1:0];
    end else if (c.mode == MODE_ENV && ok) begin
      if (on_mem[v] && env_mem[v] != {c.env_target, c.env_rate}) begin
        ramp_mem[v] = 1'b1;
      end
      env_mem[v] = {c.env_target, c.env_rate};
    end else if (c.mode == MODE_ENABLE && ok) begin
      if (c.enable && !on_mem[v]) begin
        ramp_mem[v] = 1'b1;
      end
      on_mem[v] = c.enable;
    end else if (c.mode == MODE_VOLUME && ok) begin
      vol_mem[v] = c.volume_value;
    end else if (c.mode == MODE_IRQ_READ) begin
      r.irq_voice = irq_head;
      if (irq_held) begin
        if (irq_backlog.size() != 0) begin
          irq_head = irq_backlog.pop_front();
        end else begin
          irq_held = 1'b0;
        end
      end
    end
    r.volume_out = ok ? vol_mem[v] : '0;
    r.irq_line   = irq_held;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_n++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        vol_mem[i]  = '0;
        env_mem[i]  = '0;
        on_mem[i]   = 1'b0;
        ramp_mem[i] = 1'b0;
      end
      irq_backlog.delete();
      expected_results.delete();
      irq_head = '0;
      irq_held = 1'b0;
      err_n    = 0;
      beat_n   = 0;
      done_n   = 0;
      drop_n   = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          err_n++;
          $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                   $time, res_data);
        end else begin
          want = expected_results.pop_front();
          check_field("volume_out", int'(want.volume_out), int'(res_data.volume_out));
          check_field("irq_voice", int'(want.irq_voice), int'(res_data.irq_voice));
          check_field("irq_line", int'(want.irq_line), int'(res_data.irq_line));
          check_field("completed", int'(want.completed), int'(res_data.completed));
        end
      end
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(apply_beat(cmd_data));
        beat_n++;
      end
    end
    errors      <= err_n;
    waiting     <= expected_results.size();
    beats       <= beat_n;
    completions <= done_n;
    drops       <= drop_n;
  end

endmodule

/* verif/voice_envelope_ramp_with_irq_queue_tb.sv */
// Testbench top for the voice envelope ramp block: clock, reset, command stimulus
// and result back-pressure, and the final verdict taken from vrq_checker.
// Depends on vrq_pkg, vrq_stream_if, vrq_checker and the block itself.

module voice_envelope_ramp_with_irq_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrq_pkg::*;

  localparam int ITEMS = 1150;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [VOL_W-1:0]  VOL_MAX        = {VOL_W{1'b1}};

  logic clk;
  logic rst;
  int   errors;
  int   waiting;
  int   beats;
  int   completions;
  int   drops;
  int   sent = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;

  vrq_stream_if #(.data_t(cmd_t)) cmd_if ();
  vrq_stream_if #(.data_t(res_t)) res_if ();

  voice_envelope_ramp_with_irq_queue #(.VOICES(32)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  vrq_checker #(.VOICES(32)) scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_if.valid),
    .cmd_ready   (cmd_if.ready),
    .cmd_data    (cmd_if.data),
    .res_valid   (res_if.valid),
    .res_ready   (res_if.ready),
    .res_data    (res_if.data),
    .errors      (errors),
    .waiting     (waiting),
    .beats       (beats),
    .completions (completions),
    .drops       (drops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap(input int idle_pct);
    int p;
    p = $urandom_range(0, 99);
    if (steady || p >= idle_pct) begin
      return 0;
    end
    if (p < idle_pct * 3 / 4) begin
      return $urandom_range(1, 3);
    end
    if (p < idle_pct - 2) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      stall_left = pick_gap(25);
    end
  end

  function automatic cmd_t make_cmd(input logic [MODE_W-1:0] m, input logic [VOICE_W-1:0] v,
                                    input logic [BYTE_W-1:0] rt, input logic [BYTE_W-1:0] tg,
                                    input logic en, input logic [VOL_W-1:0] vol);
    cmd_t c;
    c.mode         = m;
    c.voice        = v;
    c.env_rate     = rt;
    c.env_target   = tg;
    c.enable       = en;
    c.volume_value = vol;
    return c;
  endfunction

  task automatic send_beat(input cmd_t c);
    int gap;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sent++;
    gap = pick_gap(45);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(input logic [MODE_W-1:0] m, input logic [VOICE_W-1:0] v);
    send_beat(make_cmd(m, v, 8'($urandom), 8'($urandom), 1'($urandom), VOL_W'($urandom)));
  endtask

  task automatic maybe_read(input int read_pct);
    if ($urandom_range(0, 99) < read_pct) begin
      send_plain(MODE_IRQ_READ, 5'($urandom));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 3)) begin
      send_plain(3'($urandom), 5'($urandom));
    end
  endtask

  task automatic quick_completion(input logic [VOICE_W-1:0] v, input int read_pct);
    send_beat(make_cmd(MODE_VOLUME, v, 8'($urandom), 8'($urandom), 1'($urandom),
                       VOL_W'($urandom_range(1, 4095))));
    send_beat(make_cmd(MODE_ENV, v, 8'($urandom_range(8'h40, 8'h9f)),
                       8'($urandom_range(0, 8'h2f)), 1'($urandom), VOL_W'($urandom)));
    send_beat(make_cmd(MODE_ENABLE, v, 8'($urandom), 8'($urandom), 1'b1, VOL_W'($urandom)));
    send_plain(MODE_TICK, v);
    maybe_read(read_pct);
  endtask

  task automatic ramp_run(input int read_pct);
    logic [VOICE_W-1:0] v;
    logic [BYTE_W-1:0]  rt;
    logic [BYTE_W-1:0]  tg;
    v  = 5'($urandom);
    tg = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       rt = RATE_JUMP;
      1, 2, 3: rt = 8'($urandom_range(8'h60, 8'h7f));
      4, 5:    rt = 8'($urandom_range(8'h80, 8'hff));
      6:       rt = 8'h00;
      default: rt = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: send_beat(make_cmd(MODE_VOLUME, v, rt, tg, 1'($urandom), VOL_W'($urandom)));
      1: send_beat(make_cmd(MODE_VOLUME, v, rt, tg, 1'($urandom),
                            VOL_W'($urandom_range(0, 4095))));
      2: send_beat(make_cmd(MODE_VOLUME, v, rt, tg, 1'($urandom), '0));
      default: ;
    endcase
    send_beat(make_cmd(MODE_ENV, v, rt, tg, 1'($urandom), VOL_W'($urandom)));
    if ($urandom_range(0, 2) == 0) begin
      send_beat(make_cmd(MODE_ENABLE, v, rt, tg, 1'b0, VOL_W'($urandom)));
    end
    send_beat(make_cmd(MODE_ENABLE, v, rt, tg, 1'b1, VOL_W'($urandom)));
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_plain(MODE_TICK, 5'($urandom));
      end else begin
        send_plain(MODE_TICK, v);
      end
      maybe_read(read_pct);
    end
  endtask

  initial begin
    int  p;
    int  read_pct;
    int  settle;
    bit  flood;
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(make_cmd(MODE_IRQ_READ, 5'd0, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_VOLUME, 5'd0, 8'hff, 8'hff, 1'b1, VOL_MAX));
    send_beat(make_cmd(MODE_VOLUME, 5'd31, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_TICK, 5'd0, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENV, 5'd0, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENV, 5'd0, 8'h7f, 8'hff, 1'b0, '0));
    send_beat(make_cmd(MODE_ENABLE, 5'd0, 8'h00, 8'h00, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 5'd0, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENV, 5'd31, RATE_JUMP, 8'hff, 1'b0, '0));
    send_beat(make_cmd(MODE_ENABLE, 5'd31, 8'h00, 8'h00, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 5'd31, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_VOLUME, 5'd5, 8'h00, 8'h00, 1'b0, 26'd8192));
    send_beat(make_cmd(MODE_ENV, 5'd5, 8'h00, 8'h30, 1'b0, '0));
    send_beat(make_cmd(MODE_ENABLE, 5'd5, 8'h00, 8'h00, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 5'd5, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENV, 5'd7, 8'h80, 8'h2f, 1'b0, '0));
    send_beat(make_cmd(MODE_ENABLE, 5'd7, 8'h00, 8'h00, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 5'd7, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENV, 5'd7, 8'hf8, 8'h40, 1'b0, '0));
    send_beat(make_cmd(MODE_TICK, 5'd7, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_ENABLE, 5'd7, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_UNUSED_LO, 5'd1, 8'h00, 8'h00, 1'b0, '0));
    send_beat(make_cmd(MODE_UNUSED_HI, 5'd31, 8'hff, 8'hff, 1'b1, VOL_MAX));
    repeat (4) send_beat(make_cmd(MODE_IRQ_READ, 5'd0, 8'h00, 8'h00, 1'b0, '0));

    while (sent < ITEMS) begin
      steady   = ($urandom_range(0, 5) == 0);
      flood    = sent >= 350 && sent < 650;
      read_pct = flood ? 0 : ((sent >= 650 && sent < 800) ? 45 : 15);
      p        = $urandom_range(0, 99);
      if (p < 8 && !flood) begin
        noise_burst();
      end else if (p < (flood ? 80 : 35)) begin
        quick_completion(5'($urandom), read_pct);
      end else begin
        ramp_run(read_pct);
      end
    end
    cmd_if.valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk);

    settle = 0;
    while (waiting != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (4) @(posedge clk);

    $display("run covered %0d command beats with %0d ramp completions, %0d of them",
             beats, completions, drops);
    $display("dropped on a full interrupt queue; %0d results still outstanding", waiting);
    if (errors == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
